@@ rtl/core/sbvs_pkg.sv @@
package sbvs_pkg;

    // Field widths fixed by the interface
    localparam int WORD_W  = 32;
    localparam int TEX_W   = 64;
    localparam int BONE_W  = 6;
    localparam int WIDX_W  = 4;

    // Matrix layout: row-major 4x3, rows 0-2 rotation, row 3 translation
    localparam int WORDS_PER_BONE = 12;
    localparam int COLS           = 3;
    localparam int TRANS_BASE     = 9;

    // Parameter defaults
    localparam int BONE_COUNT_DEF = 64;
    localparam int FRAC_BITS_DEF  = 16;

    // Register stages from input accept to output register
    localparam int PIPE_DEPTH = 4;

    // Request modes
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_SKIN  = 1'b1;

    // Per-stage load enables
    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
        logic en4;
    } pipe_ctrl_t;

endpackage

@@ rtl/core/sbvs_palette.sv @@
module sbvs_palette #(
    parameter int BONE_COUNT = sbvs_pkg::BONE_COUNT_DEF
) (
    input  logic                                clk,
    input  logic                                wr_en,
    input  logic [sbvs_pkg::BONE_W-1:0]         wr_bone,
    input  logic [sbvs_pkg::WIDX_W-1:0]         wr_word,
    input  logic [sbvs_pkg::WORD_W-1:0]         wr_data,
    input  logic                                rd_en,
    input  logic [sbvs_pkg::BONE_W-1:0]         rd_bone,
    output logic signed [sbvs_pkg::WORD_W-1:0]  rd_words [sbvs_pkg::WORDS_PER_BONE]
);

    localparam int ADDR_W = (BONE_COUNT > 1) ? $clog2(BONE_COUNT) : 1;

    logic [ADDR_W-1:0]               wr_addr;
    logic [ADDR_W-1:0]               rd_addr;
    logic                            wr_ok;
    logic                            rd_ok;
    logic                            bone_ok_reg;
    logic [sbvs_pkg::WORD_W-1:0]     q_reg [sbvs_pkg::WORDS_PER_BONE];

    assign wr_addr = ADDR_W'(wr_bone);
    assign rd_addr = ADDR_W'(rd_bone);
    assign wr_ok   = int'(wr_bone) < BONE_COUNT;
    assign rd_ok   = int'(rd_bone) < BONE_COUNT;

    // One bank per matrix word so all words of a matrix are read together
    for (genvar w = 0; w < sbvs_pkg::WORDS_PER_BONE; w++)
    begin : g_bank
        logic [sbvs_pkg::WORD_W-1:0] bank_mem [BONE_COUNT];

        always_ff @(posedge clk)
        begin
            if (wr_en && wr_ok && (wr_word == sbvs_pkg::WIDX_W'(w)))
            begin
                bank_mem[wr_addr] <= wr_data;
            end
            if (rd_en)
            begin
                q_reg[w] <= bank_mem[rd_addr];
            end
        end

        // Out-of-range bone reads as an all-zero matrix
        assign rd_words[w] = bone_ok_reg ? signed'(q_reg[w]) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            bone_ok_reg <= rd_ok;
        end
    end

endmodule

@@ rtl/core/sbvs_dot.sv @@
module sbvs_dot #(
    parameter int FRAC_BITS = sbvs_pkg::FRAC_BITS_DEF,
    localparam int PW = 2 * sbvs_pkg::WORD_W - FRAC_BITS,
    localparam int SW = PW + 2
) (
    input  logic                               clk,
    input  sbvs_pkg::pipe_ctrl_t               ctrl,
    input  logic signed [sbvs_pkg::WORD_W-1:0] vec_x,
    input  logic signed [sbvs_pkg::WORD_W-1:0] vec_y,
    input  logic signed [sbvs_pkg::WORD_W-1:0] vec_z,
    input  logic signed [sbvs_pkg::WORD_W-1:0] col0,
    input  logic signed [sbvs_pkg::WORD_W-1:0] col1,
    input  logic signed [sbvs_pkg::WORD_W-1:0] col2,
    input  logic signed [sbvs_pkg::WORD_W-1:0] offset,
    output logic signed [SW-1:0]               sum
);

    localparam int PROD_W = 2 * sbvs_pkg::WORD_W;

    logic signed [PROD_W-1:0]           prod0;
    logic signed [PROD_W-1:0]           prod1;
    logic signed [PROD_W-1:0]           prod2;
    logic signed [PW-1:0]               p0_reg;
    logic signed [PW-1:0]               p1_reg;
    logic signed [PW-1:0]               p2_reg;
    logic signed [sbvs_pkg::WORD_W-1:0] off_reg;
    logic signed [SW-1:0]               sum_next;
    logic signed [SW-1:0]               sum_reg;

    // Stage 2: exact products, low fraction bits dropped (floor)
    assign prod0 = vec_x * col0;
    assign prod1 = vec_y * col1;
    assign prod2 = vec_z * col2;

    always_ff @(posedge clk)
    begin
        if (ctrl.en2)
        begin
            p0_reg  <= prod0[PROD_W-1:FRAC_BITS];
            p1_reg  <= prod1[PROD_W-1:FRAC_BITS];
            p2_reg  <= prod2[PROD_W-1:FRAC_BITS];
            off_reg <= offset;
        end
    end

    // Stage 3: exact sum, saturation follows in the output stage
    assign sum_next = SW'(p0_reg) + SW'(p1_reg) + SW'(p2_reg) + SW'(off_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl.en3)
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

@@ rtl/core/single_bone_vertex_skinning_top.sv @@
// Channel | Handshake           | Carries
// --------+---------------------+-------------------------------------------------------
// input   | in_valid/in_ready   | mode, palette bone/word/value, vertex pos/nrm/tex/last
// output  | out_valid/out_ready | out_pos_*, out_nrm_*, out_texcoords, out_last
//
// One request per clock while in_ready is high, palette writes and vertices alike;
// writes give no result. Four register stages (palette read, multiply, sum, saturate)
// carry an accepted vertex in that order to the output register and out_valid.
// A palette write is seen by a vertex accepted on the very next cycle.
// Reset clears only the stage valid bits; palette words are undefined until written.
// A held output stalls only the stages behind it; empty stages keep taking requests.
module single_bone_vertex_skinning_top #(
    parameter int BONE_COUNT = sbvs_pkg::BONE_COUNT_DEF,
    parameter int FRAC_BITS  = sbvs_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                mode,
    input  logic [sbvs_pkg::BONE_W-1:0]         bone_index,
    input  logic [sbvs_pkg::WIDX_W-1:0]         word_index,
    input  logic signed [sbvs_pkg::WORD_W-1:0]  word_value,
    input  logic signed [sbvs_pkg::WORD_W-1:0]  pos_x,
    input  logic signed [sbvs_pkg::WORD_W-1:0]  pos_y,
    input  logic signed [sbvs_pkg::WORD_W-1:0]  pos_z,
    input  logic signed [sbvs_pkg::WORD_W-1:0]  nrm_x,
    input  logic signed [sbvs_pkg::WORD_W-1:0]  nrm_y,
    input  logic signed [sbvs_pkg::WORD_W-1:0]  nrm_z,
    input  logic [sbvs_pkg::TEX_W-1:0]          texcoords,
    input  logic                                last_vertex,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [sbvs_pkg::WORD_W-1:0]  out_pos_x,
    output logic signed [sbvs_pkg::WORD_W-1:0]  out_pos_y,
    output logic signed [sbvs_pkg::WORD_W-1:0]  out_pos_z,
    output logic signed [sbvs_pkg::WORD_W-1:0]  out_nrm_x,
    output logic signed [sbvs_pkg::WORD_W-1:0]  out_nrm_y,
    output logic signed [sbvs_pkg::WORD_W-1:0]  out_nrm_z,
    output logic [sbvs_pkg::TEX_W-1:0]          out_texcoords,
    output logic                                out_last
);

    localparam int WW = sbvs_pkg::WORD_W;
    localparam int PW = 2 * WW - FRAC_BITS;
    localparam int SW = PW + 2;
    localparam int NL = 2 * sbvs_pkg::COLS;

    // Clamp an exact sum to the signed word range
    function automatic logic [WW-1:0] sat_word(input logic signed [SW-1:0] s);
        logic [SW-WW:0] hi;
        logic [WW-1:0]  r;
        hi = s[SW-1:WW-1];
        if ((&hi) || !(|hi))
        begin
            r = s[WW-1:0];
        end
        else if (s[SW-1])
        begin
            r = {1'b1, {(WW-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(WW-1){1'b1}}};
        end
        return r;
    endfunction

    sbvs_pkg::pipe_ctrl_t ctrl;

    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic v4_reg;
    logic accept;
    logic wr_req;
    logic vtx_req;

    logic signed [WW-1:0]             pos1_reg [sbvs_pkg::COLS];
    logic signed [WW-1:0]             nrm1_reg [sbvs_pkg::COLS];
    logic [sbvs_pkg::TEX_W-1:0]       tex_reg  [sbvs_pkg::PIPE_DEPTH];
    logic                             last_reg [sbvs_pkg::PIPE_DEPTH];
    logic signed [WW-1:0]             mat      [sbvs_pkg::WORDS_PER_BONE];
    logic signed [SW-1:0]             lane_sum [NL];
    logic [WW-1:0]                    res_reg  [NL];

    // Stage readiness ripples back from the output register
    always_comb
    begin
        ctrl.en4 = !v4_reg || out_ready;
        ctrl.en3 = !v3_reg || ctrl.en4;
        ctrl.en2 = !v2_reg || ctrl.en3;
        ctrl.en1 = !v1_reg || ctrl.en2;
    end

    assign in_ready = ctrl.en1;
    assign accept   = in_valid && in_ready;
    assign wr_req   = accept && (mode == sbvs_pkg::MODE_WRITE);
    assign vtx_req  = accept && (mode == sbvs_pkg::MODE_SKIN);

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.en1)
            begin
                v1_reg <= vtx_req;
            end
            if (ctrl.en2)
            begin
                v2_reg <= v1_reg;
            end
            if (ctrl.en3)
            begin
                v3_reg <= v2_reg;
            end
            if (ctrl.en4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // Stage 1: palette read plus vertex capture
    sbvs_palette #(
        .BONE_COUNT (BONE_COUNT)
    ) u_palette (
        .clk      (clk),
        .wr_en    (wr_req),
        .wr_bone  (bone_index),
        .wr_word  (word_index),
        .wr_data  (word_value),
        .rd_en    (ctrl.en1),
        .rd_bone  (bone_index),
        .rd_words (mat)
    );

    always_ff @(posedge clk)
    begin
        if (ctrl.en1)
        begin
            pos1_reg[0] <= pos_x;
            pos1_reg[1] <= pos_y;
            pos1_reg[2] <= pos_z;
            nrm1_reg[0] <= nrm_x;
            nrm1_reg[1] <= nrm_y;
            nrm1_reg[2] <= nrm_z;
            tex_reg[0]  <= texcoords;
            last_reg[0] <= last_vertex;
        end
        if (ctrl.en2)
        begin
            tex_reg[1]  <= tex_reg[0];
            last_reg[1] <= last_reg[0];
        end
        if (ctrl.en3)
        begin
            tex_reg[2]  <= tex_reg[1];
            last_reg[2] <= last_reg[1];
        end
        if (ctrl.en4)
        begin
            tex_reg[3]  <= tex_reg[2];
            last_reg[3] <= last_reg[2];
        end
    end

    // Stages 2-3: one dot-product lane per output coordinate
    for (genvar c = 0; c < sbvs_pkg::COLS; c++)
    begin : g_lane
        sbvs_dot #(
            .FRAC_BITS (FRAC_BITS)
        ) u_pos (
            .clk    (clk),
            .ctrl   (ctrl),
            .vec_x  (pos1_reg[0]),
            .vec_y  (pos1_reg[1]),
            .vec_z  (pos1_reg[2]),
            .col0   (mat[c]),
            .col1   (mat[sbvs_pkg::COLS + c]),
            .col2   (mat[2 * sbvs_pkg::COLS + c]),
            .offset (mat[sbvs_pkg::TRANS_BASE + c]),
            .sum    (lane_sum[c])
        );

        // Normal: rotation only
        sbvs_dot #(
            .FRAC_BITS (FRAC_BITS)
        ) u_nrm (
            .clk    (clk),
            .ctrl   (ctrl),
            .vec_x  (nrm1_reg[0]),
            .vec_y  (nrm1_reg[1]),
            .vec_z  (nrm1_reg[2]),
            .col0   (mat[c]),
            .col1   (mat[sbvs_pkg::COLS + c]),
            .col2   (mat[2 * sbvs_pkg::COLS + c]),
            .offset ('0),
            .sum    (lane_sum[sbvs_pkg::COLS + c])
        );
    end

    // Stage 4: saturate into the output register
    for (genvar l = 0; l < NL; l++)
    begin : g_out
        always_ff @(posedge clk)
        begin
            if (ctrl.en4)
            begin
                res_reg[l] <= sat_word(lane_sum[l]);
            end
        end
    end

    assign out_valid     = v4_reg;
    assign out_pos_x     = res_reg[0];
    assign out_pos_y     = res_reg[1];
    assign out_pos_z     = res_reg[2];
    assign out_nrm_x     = res_reg[3];
    assign out_nrm_y     = res_reg[4];
    assign out_nrm_z     = res_reg[5];
    assign out_texcoords = tex_reg[3];
    assign out_last      = last_reg[3];

endmodule

@@ rtl/core/sbvs_checker.sv @@
module sbvs_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                mode,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [sbvs_pkg::WORD_W-1:0]  out_pos_x,
    input logic signed [sbvs_pkg::WORD_W-1:0]  out_nrm_z,
    input logic [sbvs_pkg::TEX_W-1:0]          out_texcoords,
    input logic                                out_last
);

    localparam int CNT_W = $clog2(sbvs_pkg::PIPE_DEPTH + 2);

    logic [CNT_W-1:0] inflight_reg;
    logic [CNT_W-1:0] inflight_next;
    logic             vtx_in;
    logic             res_out;

    assign vtx_in  = in_valid && in_ready && (mode == sbvs_pkg::MODE_SKIN);
    assign res_out = out_valid && out_ready;

    // Vertices accepted but not yet delivered
    always_comb
    begin
        inflight_next = inflight_reg;
        if (vtx_in && !res_out)
        begin
            inflight_next = inflight_reg + CNT_W'(1);
        end
        else if (!vtx_in && res_out)
        begin
            inflight_next = inflight_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // Held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_pos_x) && $stable(out_nrm_z)
            && $stable(out_texcoords) && $stable(out_last))
        else $error("output changed while stalled");

    // No result without a vertex behind it
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> inflight_reg != '0)
        else $error("result with no vertex in flight");

    // Never more vertices in flight than stages
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= CNT_W'(sbvs_pkg::PIPE_DEPTH))
        else $error("more vertices in flight than pipeline stages");

    // An empty pipeline always takes requests
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg == '0 |-> in_ready)
        else $error("stalled with empty pipeline");

endmodule

bind single_bone_vertex_skinning_top sbvs_checker u_sbvs_checker (.*);

@@ tb/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sbvs_pkg::*;

    localparam int BONES       = BONE_COUNT_DEF;
    localparam int FRAC        = FRAC_BITS_DEF;
    localparam int DIR_BONE    = BONES - 1;
    localparam int MAX_WIDX    = (1 << WIDX_W) - 1;
    localparam int RAND_ITEMS  = 1225;
    localparam int LONG_HOLD   = 300;
    localparam int STALL_LIMIT = 3000;
    localparam int MAX_REPORTS = 10;
    localparam int unsigned COORD_SPAN = 32'h0010_0000;  // +-8.0
    localparam int unsigned MWORD_SPAN = 32'h0004_0000;  // +-2.0

    // One request as queued for the driver
    typedef struct {
        logic              mode;
        logic [BONE_W-1:0] bone;
        logic [WIDX_W-1:0] widx;
        logic [WORD_W-1:0] wval;
        logic [WORD_W-1:0] px, py, pz, nx, ny, nz;
        logic [TEX_W-1:0]  tex;
        logic              last;
        int                phase;
        bit                drain;
        bit                hold;
    } skin_req_t;

    // One skinned vertex as it should leave the block
    typedef struct packed {
        logic [WORD_W-1:0] px, py, pz, nx, ny, nz;
        logic [TEX_W-1:0]  tex;
        logic              last;
    } skinned_vtx_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic mode = MODE_WRITE;
    logic [BONE_W-1:0] bone_index = '0;
    logic [WIDX_W-1:0] word_index = '0;
    logic signed [WORD_W-1:0] word_value = '0;
    logic signed [WORD_W-1:0] pos_x = '0;
    logic signed [WORD_W-1:0] pos_y = '0;
    logic signed [WORD_W-1:0] pos_z = '0;
    logic signed [WORD_W-1:0] nrm_x = '0;
    logic signed [WORD_W-1:0] nrm_y = '0;
    logic signed [WORD_W-1:0] nrm_z = '0;
    logic [TEX_W-1:0] texcoords = '0;
    logic last_vertex = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [WORD_W-1:0] out_pos_x, out_pos_y, out_pos_z;
    logic [WORD_W-1:0] out_nrm_x, out_nrm_y, out_nrm_z;
    logic [TEX_W-1:0] out_texcoords;
    logic out_last;

    single_bone_vertex_skinning_top u_dut (.*);

    // Stimulus and expectation stores
    skin_req_t    req_q [$];
    skinned_vtx_t vert_q [$];

    // Generator bookkeeping: which palette words have been written so far
    logic [WORDS_PER_BONE-1:0] gen_words [BONES];
    bit  bone_full [BONES];
    int  full_bones [$];
    int  gen_phase = 0;
    bit  gen_drain = 1'b0;
    bit  gen_hold = 1'b0;
    int  n_queued = 0;

    // Palette copy used for prediction
    logic signed [WORD_W-1:0] palette_mdl [BONES * WORDS_PER_BONE];

    // Handshake and run bookkeeping
    bit in_taken = 1'b0;
    int phase_now = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int stall_cycles = 0;
    int n_mismatch = 0;
    int n_checked = 0;
    int n_writes = 0;
    int n_ignored = 0;
    int n_sat = 0;

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic int idle_pct(int ph, bit receiver);
        case (ph)
            0:       return receiver ? 80 : 6;
            1:       return receiver ? 6 : 80;
            default: return 0;
        endcase
    endfunction

    // Q16.16 value: mostly moderate, sometimes full range or an edge value
    function automatic logic [WORD_W-1:0] rand_q16(int unsigned span);
        case ($urandom_range(9))
            0:
            begin
                case ($urandom_range(5))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'h0000_0000;
                    3:       return 32'h0000_0001;
                    4:       return 32'hFFFF_FFFF;
                    default: return 32'h0001_0000;
                endcase
            end
            1, 2:    return $urandom;
            default: return $urandom_range(span - 1) - span / 2;
        endcase
    endfunction

    function automatic skin_req_t rand_req();
        skin_req_t r;
        r.mode  = MODE_SKIN;
        r.bone  = BONE_W'($urandom);
        r.widx  = WIDX_W'($urandom);
        r.wval  = rand_q16(MWORD_SPAN);
        r.px    = rand_q16(COORD_SPAN);
        r.py    = rand_q16(COORD_SPAN);
        r.pz    = rand_q16(COORD_SPAN);
        r.nx    = rand_q16(COORD_SPAN);
        r.ny    = rand_q16(COORD_SPAN);
        r.nz    = rand_q16(COORD_SPAN);
        r.tex   = {$urandom, $urandom};
        r.last  = ($urandom_range(7) == 0);
        r.phase = 0;
        r.drain = 1'b0;
        r.hold  = 1'b0;
        return r;
    endfunction

    task automatic queue_req(skin_req_t r);
        r.phase = gen_phase;
        r.drain = gen_drain;
        r.hold  = gen_hold;
        gen_drain = 1'b0;
        gen_hold  = 1'b0;
        req_q.push_back(r);
        if (r.mode == MODE_SKIN || int'(r.widx) < WORDS_PER_BONE)
            n_queued++;
    endtask

    task automatic put_word(int bone, int widx, logic [WORD_W-1:0] val);
        skin_req_t r;
        r = rand_req();
        r.mode = MODE_WRITE;
        r.bone = BONE_W'(bone);
        r.widx = WIDX_W'(widx);
        r.wval = val;
        queue_req(r);
        if (widx < WORDS_PER_BONE)
        begin
            gen_words[bone][widx] = 1'b1;
            if (&gen_words[bone] && !bone_full[bone])
            begin
                bone_full[bone] = 1'b1;
                full_bones.push_back(bone);
            end
        end
    endtask

    task automatic put_vertex(int bone, logic [WORD_W-1:0] px, logic [WORD_W-1:0] py,
                              logic [WORD_W-1:0] pz, logic [WORD_W-1:0] nx,
                              logic [WORD_W-1:0] ny, logic [WORD_W-1:0] nz,
                              logic [TEX_W-1:0] tex, logic last);
        skin_req_t r;
        r = rand_req();
        r.bone = BONE_W'(bone);
        r.px = px;
        r.py = py;
        r.pz = pz;
        r.nx = nx;
        r.ny = ny;
        r.nz = nz;
        r.tex = tex;
        r.last = last;
        queue_req(r);
    endtask

    // Mostly whole-bone loads and vertices on fully loaded bones, some
    // single-word updates and some writes to words past the matrix end
    task automatic random_step();
        int r;
        int b;
        skin_req_t q;
        r = $urandom_range(99);
        if (r < 10 || full_bones.size() == 0)
        begin
            b = $urandom_range(BONES - 1);
            if (full_bones.size() < BONES)
                while (bone_full[b])
                    b = (b + 1) % BONES;
            for (int w = 0; w < WORDS_PER_BONE; w++)
                put_word(b, w, rand_q16(MWORD_SPAN));
        end
        else if (r < 22)
            put_word($urandom_range(BONES - 1), $urandom_range(WORDS_PER_BONE - 1),
                     rand_q16(MWORD_SPAN));
        else if (r < 26)
            put_word($urandom_range(BONES - 1), $urandom_range(MAX_WIDX, WORDS_PER_BONE),
                     $urandom);
        else
        begin
            q = rand_req();
            q.bone = BONE_W'(full_bones[$urandom_range(full_bones.size() - 1)]);
            queue_req(q);
        end
    endtask

    // floor(a*b / 2^FRAC)
    function automatic longint fx_mul(longint a, longint b);
        return (a * b) >>> FRAC;
    endfunction

    function automatic logic [WORD_W-1:0] sat_word(longint s);
        if (s > 64'sd2147483647)
            return 32'h7FFF_FFFF;
        if (s < -64'sd2147483648)
            return 32'h8000_0000;
        return s[WORD_W-1:0];
    endfunction

    // Apply the request on the input ports to the palette copy, or skin it
    task automatic model_request();
        longint m [WORDS_PER_BONE];
        longint pv [COLS];
        longint nv [COLS];
        longint sp;
        longint sn;
        logic [WORD_W-1:0] lane [2 * COLS];
        skinned_vtx_t e;
        if (mode == MODE_WRITE)
        begin
            if (int'(bone_index) < BONES && int'(word_index) < WORDS_PER_BONE)
            begin
                palette_mdl[int'(bone_index) * WORDS_PER_BONE + int'(word_index)] = word_value;
                n_writes++;
            end
            else
                n_ignored++;
        end
        else
        begin
            for (int i = 0; i < WORDS_PER_BONE; i++)
                m[i] = (int'(bone_index) < BONES) ?
                       longint'(palette_mdl[int'(bone_index) * WORDS_PER_BONE + i]) : 0;
            pv[0] = longint'(pos_x);
            pv[1] = longint'(pos_y);
            pv[2] = longint'(pos_z);
            nv[0] = longint'(nrm_x);
            nv[1] = longint'(nrm_y);
            nv[2] = longint'(nrm_z);
            for (int c = 0; c < COLS; c++)
            begin
                sp = m[TRANS_BASE + c];
                sn = 0;
                for (int r = 0; r < COLS; r++)
                begin
                    sp += fx_mul(pv[r], m[r * COLS + c]);
                    sn += fx_mul(nv[r], m[r * COLS + c]);
                end
                lane[c] = sat_word(sp);
                lane[COLS + c] = sat_word(sn);
                if (sp != longint'($signed(lane[c])))
                    n_sat++;
                if (sn != longint'($signed(lane[COLS + c])))
                    n_sat++;
            end
            e.px = lane[0];
            e.py = lane[1];
            e.pz = lane[2];
            e.nx = lane[3];
            e.ny = lane[4];
            e.nz = lane[5];
            e.tex = texcoords;
            e.last = last_vertex;
            vert_q.push_back(e);
        end
    endtask

    task automatic check_lane(string lane, logic [TEX_W-1:0] want, logic [TEX_W-1:0] got);
        if (want !== got)
        begin
            n_mismatch++;
            if (n_mismatch <= MAX_REPORTS)
                $display("mismatch on %s of vertex %0d: expected %0h, got %0h",
                         lane, n_checked, want, got);
        end
    endtask

    task automatic check_vertex();
        skinned_vtx_t e;
        if (vert_q.size() == 0)
        begin
            n_mismatch++;
            if (n_mismatch <= MAX_REPORTS)
                $display("vertex out with none pending: pos %0h %0h %0h",
                         out_pos_x, out_pos_y, out_pos_z);
        end
        else
        begin
            e = vert_q.pop_front();
            check_lane("out_pos_x", e.px, out_pos_x);
            check_lane("out_pos_y", e.py, out_pos_y);
            check_lane("out_pos_z", e.pz, out_pos_z);
            check_lane("out_nrm_x", e.nx, out_nrm_x);
            check_lane("out_nrm_y", e.ny, out_nrm_y);
            check_lane("out_nrm_z", e.nz, out_nrm_z);
            check_lane("out_texcoords", e.tex, out_texcoords);
            check_lane("out_last", e.last, out_last);
            n_checked++;
        end
    endtask

    // Sample both handshakes at the rising edge
    always @(posedge clk)
    begin
        in_taken = in_valid && in_ready;
        if (in_taken)
            model_request();
        if (out_valid === 1'b1 && out_ready)
            check_vertex();
        if (in_taken || (out_valid === 1'b1 && out_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
    end

    // Request driver: holds valid until taken, idles per phase, can wait
    // for the pipe to drain and can trigger a long output hold
    always @(negedge clk)
    begin
        skin_req_t nxt;
        bit offer;
        offer = in_valid && !in_taken;
        if (rst_n && !offer && req_q.size() > 0)
        begin
            nxt = req_q[0];
            if (!(nxt.drain && vert_q.size() != 0) &&
                $urandom_range(99) >= idle_pct(nxt.phase, 1'b0))
            begin
                void'(req_q.pop_front());
                mode        <= nxt.mode;
                bone_index  <= nxt.bone;
                word_index  <= nxt.widx;
                word_value  <= nxt.wval;
                pos_x       <= nxt.px;
                pos_y       <= nxt.py;
                pos_z       <= nxt.pz;
                nrm_x       <= nxt.nx;
                nrm_y       <= nxt.ny;
                nrm_z       <= nxt.nz;
                texcoords   <= nxt.tex;
                last_vertex <= nxt.last;
                phase_now   <= nxt.phase;
                if (nxt.hold)
                    hold_req <= hold_req + 1;
                offer = 1'b1;
            end
        end
        in_valid <= offer;
    end

    // Output side ready: long hold on request, otherwise random per phase
    always @(negedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= LONG_HOLD;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= idle_pct(phase_now, 1'b1));
    end

    // Watchdog on cycles with no request moving on either side
    initial
    begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("watchdog: no request moved for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        int base;
        for (int b = 0; b < BONES; b++)
        begin
            gen_words[b] = '0;
            bone_full[b] = 1'b0;
        end

        // Directed: one bone loaded with unit values and full-scale edge values
        put_word(DIR_BONE, 0, 32'h0001_0000);
        put_word(DIR_BONE, 1, 32'h7FFF_FFFF);
        put_word(DIR_BONE, 2, 32'h8000_0000);
        put_word(DIR_BONE, 3, 32'hFFFF_0000);
        put_word(DIR_BONE, 4, 32'h0001_0000);
        put_word(DIR_BONE, 5, 32'h0000_0000);
        put_word(DIR_BONE, 6, 32'h0000_8000);
        put_word(DIR_BONE, 7, 32'h8000_0000);
        put_word(DIR_BONE, 8, 32'h0001_0000);
        put_word(DIR_BONE, 9, 32'h0001_0000);
        put_word(DIR_BONE, 10, 32'h7FFF_FFFF);
        put_word(DIR_BONE, 11, 32'h8000_0000);
        // origin gives the translation row; then unit values, saturation
        // both ways, and single-LSB inputs for floor rounding
        put_vertex(DIR_BONE, 0, 0, 0, 0, 0, 0, '0, 1'b0);
        put_vertex(DIR_BONE, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000,
                   32'h0001_0000, 0, 0, '1, 1'b1);
        put_vertex(DIR_BONE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 64'h5555_AAAA_0F0F_F0F0, 1'b0);
        put_vertex(DIR_BONE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 64'hAAAA_5555_F0F0_0F0F, 1'b1);
        put_vertex(DIR_BONE, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF,
                   32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001, {$urandom, $urandom}, 1'b0);
        // words past the matrix end are dropped, even where they would alias
        put_word(DIR_BONE - 1, WORDS_PER_BONE + 2, 32'h1234_5678);
        put_word(DIR_BONE, WORDS_PER_BONE, 32'h1234_5678);
        put_word(0, MAX_WIDX, 32'h1234_5678);
        put_vertex(DIR_BONE, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                   32'h0001_0000, 32'h0001_0000, 32'h0001_0000, {$urandom, $urandom}, 1'b0);
        // vertex right behind a write to its own bone
        put_word(DIR_BONE, TRANS_BASE, 32'h8000_0000);
        put_vertex(DIR_BONE, 0, 0, 0, 32'h0002_0000, 0, 0, {$urandom, $urandom}, 1'b1);

        // Random part in three stall profiles; each opens on a drained pipe
        base = n_queued;
        for (int ph = 0; ph < 3; ph++)
        begin
            gen_phase = ph;
            gen_drain = 1'b1;
            gen_hold  = (ph == 2);
            while (n_queued < base + (ph + 1) * RAND_ITEMS / 3)
                random_step();
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (req_q.size() != 0 || in_valid || vert_q.size() != 0)
            @(negedge clk);
        repeat (PIPE_DEPTH * 4) @(negedge clk);

        $display("Covered %0d palette writes (%0d past the matrix end), %0d vertices checked,",
                 n_writes, n_ignored, n_checked);
        $display("%0d saturated lanes, three stall profiles and a %0d-cycle output hold.",
                 n_sat, LONG_HOLD);
        if (n_mismatch == 0 && vert_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/sbvs_pkg.sv
rtl/core/sbvs_palette.sv
rtl/core/sbvs_dot.sv
rtl/core/single_bone_vertex_skinning_top.sv
rtl/core/sbvs_checker.sv
tb/tb.sv
